// File: sv/rgb2yuv_pkg.sv
// Shared constants for the RGB to YCbCr converter with chroma subsampling.
// Holds the BT.601 integer coefficients, register map and reset values.
// No dependencies; imported by the top level and its checker.
package rgb2yuv_pkg;

    // Line store sizing default.
    localparam int MAX_WIDTH_DEF = 1024;

    // Field widths.
    localparam int PIX_W  = 8;
    localparam int MODE_W = 2;
    localparam int LINE_W = 11;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register map, word index taken from paddr[2].
    localparam logic REG_CHROMA_MODE = 1'b0;
    localparam logic REG_LINE_WIDTH  = 1'b1;

    // Chroma modes; the unused code behaves as 4:2:0.
    localparam logic [MODE_W-1:0] MODE_444 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_422 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_420 = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [MODE_W-1:0] CHROMA_MODE_RST = MODE_420;
    localparam logic [LINE_W-1:0] LINE_WIDTH_RST  = 11'd352;

    // BT.601 coefficient magnitudes; signs are applied in the datapath.
    localparam int C_Y_R  = 66;
    localparam int C_Y_G  = 129;
    localparam int C_Y_B  = 25;
    localparam int C_CB_R = 38;
    localparam int C_CB_G = 74;
    localparam int C_CB_B = 112;
    localparam int C_CR_R = 112;
    localparam int C_CR_G = 94;
    localparam int C_CR_B = 18;
    localparam int C_ROUND = 128;
    localparam int C_Y_OFS = 16;
    // Rounding term plus the chroma offset of 128 scaled by 256.
    localparam int C_C_OFS = 128 + 32768;

    // Legal output ranges.
    localparam int LUMA_MIN   = 16;
    localparam int LUMA_MAX   = 235;
    localparam int CHROMA_MIN = 16;
    localparam int CHROMA_MAX = 240;

endpackage

// File: sv/rgb_to_yuv_chroma_subsampler.sv
// Top level of the RGB to YCbCr converter with 4:4:4, 4:2:2 and 4:2:0 output.
// Holds the APB register file, the converter pipeline and the chroma line store.
// Depends on rgb2yuv_pkg.
//
//   Channel     | Direction | Beat contents
//   ------------+-----------+---------------------------------------------
//   s_axis      | in        | tdata: red, green, blue; tuser: frame_start
//   m_axis      | out       | tdata: luma, cb, cr; tuser: chroma_valid
//   APB         | in/out    | chroma_mode at 0x0, line_width at 0x4
//
// One pixel is accepted per clock cycle unless the output stalls.
// The line store has one read port and one write port, each used at most once
// per pixel, so it never limits the rate. Reset is synchronous and active low;
// the line store is not cleared and needs no pass after reset. When the output
// register is full and not taken, it holds its beat; s_axis_tready drops only
// once stage one also holds a pixel, and then both stages hold.
module rgb_to_yuv_chroma_subsampler #(
    parameter int MAX_WIDTH = rgb2yuv_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgb2yuv_pkg::APB_AW-1:0]  paddr,
    input  logic [rgb2yuv_pkg::APB_DW-1:0]  pwdata,
    output logic [rgb2yuv_pkg::APB_DW-1:0]  prdata,
    output logic                            pready,
    // Pixel input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    input  logic                            s_axis_tuser,  // frame_start
    // Converted output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // luma[7:0], cb[15:8], cr[23:16]
    output logic                            m_axis_tuser   // chroma_valid
);
    import rgb2yuv_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW_W   = COL_W + 1;
    localparam int DEPTH  = MAX_WIDTH / 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = 17;

    // What stage one hands to the output stage for chroma.
    localparam logic [1:0] CK_NONE   = 2'd0;
    localparam logic [1:0] CK_DIRECT = 2'd1;
    localparam logic [1:0] CK_AVG    = 2'd2;

    // Configuration registers
    logic [MODE_W-1:0] r_chroma_mode;
    logic [LINE_W-1:0] r_line_width;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chroma_mode <= CHROMA_MODE_RST;
            r_line_width  <= LINE_WIDTH_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_CHROMA_MODE) begin
                r_chroma_mode <= pwdata[MODE_W-1:0];
            end else begin
                r_line_width <= pwdata[LINE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_CHROMA_MODE) begin
            prdata = {{(APB_DW-MODE_W){1'b0}}, r_chroma_mode};
        end else begin
            prdata = {{(APB_DW-LINE_W){1'b0}}, r_line_width};
        end
    end

    // Pipeline handshake: stage one advances into the output register when
    // that register is empty or being drained this cycle.
    logic r_s1_valid;
    logic r_out_valid;
    logic w_s2_load;
    logic w_accept;

    assign w_s2_load     = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s2_load;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Color matrix on the incoming beat
    logic [PIX_W-1:0] w_red, w_green, w_blue;
    logic [SUM_W-1:0] w_y_sum, w_cb_sum, w_cr_sum;
    logic [PIX_W-1:0] w_luma, w_cb, w_cr;

    assign w_red   = s_axis_tdata[7:0];
    assign w_green = s_axis_tdata[15:8];
    assign w_blue  = s_axis_tdata[23:16];

    // Sums stay below 2^16; the chroma offset keeps them non-negative, so the
    // byte above bit 7 is the arithmetic shift result plus 128.
    assign w_y_sum  = SUM_W'(C_Y_R * w_red) + SUM_W'(C_Y_G * w_green)
                    + SUM_W'(C_Y_B * w_blue) + SUM_W'(C_ROUND);
    assign w_cb_sum = SUM_W'(C_CB_B * w_blue) - SUM_W'(C_CB_R * w_red)
                    - SUM_W'(C_CB_G * w_green) + SUM_W'(C_C_OFS);
    assign w_cr_sum = SUM_W'(C_CR_R * w_red) - SUM_W'(C_CR_G * w_green)
                    - SUM_W'(C_CR_B * w_blue) + SUM_W'(C_C_OFS);

    assign w_luma = w_y_sum[15:8] + PIX_W'(C_Y_OFS);
    assign w_cb   = w_cb_sum[15:8];
    assign w_cr   = w_cr_sum[15:8];

    // Line position; a frame start clears it before the pixel is placed.
    logic [COL_W-1:0]  r_column, n_column;
    logic              r_odd_row, n_odd_row;
    logic [COL_W-1:0]  w_col;
    logic              w_odd;
    logic [EW_W-1:0]   w_eff_width;
    logic [EW_W-1:0]   w_col_inc;

    assign w_col = s_axis_tuser ? '0 : r_column;
    assign w_odd = s_axis_tuser ? 1'b0 : r_odd_row;

    // Effective width: clamped to the legal range and made even.
    always_comb begin
        if (32'(r_line_width) < 32'd2) begin
            w_eff_width = EW_W'(2);
        end else if (32'(r_line_width) > 32'(MAX_WIDTH)) begin
            w_eff_width = EW_W'(MAX_WIDTH);
        end else begin
            w_eff_width = EW_W'(r_line_width);
        end
        w_eff_width[0] = 1'b0;
    end

    assign w_col_inc = EW_W'(w_col) + EW_W'(1);

    always_comb begin
        n_column  = r_column;
        n_odd_row = r_odd_row;
        if (w_accept) begin
            if (w_col_inc >= w_eff_width) begin
                n_column  = '0;
                n_odd_row = !w_odd;
            end else begin
                n_column  = w_col_inc[COL_W-1:0];
                n_odd_row = w_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column  <= '0;
            r_odd_row <= 1'b0;
        end else begin
            r_column  <= n_column;
            r_odd_row <= n_odd_row;
        end
    end

    // Chroma decision per mode: even rows of 4:2:0 write the store, odd rows
    // read it back for averaging.
    logic [1:0]        w_kind;
    logic              w_mem_wr, w_mem_rd;
    logic [ADDR_W-1:0] w_addr;

    assign w_addr = ADDR_W'(w_col >> 1);

    always_comb begin
        w_kind   = CK_NONE;
        w_mem_wr = 1'b0;
        w_mem_rd = 1'b0;
        case (r_chroma_mode)
            MODE_444: begin
                w_kind = CK_DIRECT;
            end
            MODE_422: begin
                if (!w_col[0]) begin
                    w_kind = CK_DIRECT;
                end
            end
            default: begin
                if (!w_col[0]) begin
                    if (w_odd) begin
                        w_kind   = CK_AVG;
                        w_mem_rd = 1'b1;
                    end else begin
                        w_mem_wr = 1'b1;
                    end
                end
            end
        endcase
    end

    // Line store of even-row chroma, cb in the high byte. A write and a read
    // of one entry always belong to different rows, so the write has landed
    // before the odd row reads it. The read data holds while the pipe stalls.
    logic [15:0] r_chroma_line [DEPTH];
    logic [15:0] r_mem_q;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_mem_wr) begin
            r_chroma_line[w_addr] <= {w_cb, w_cr};
        end
        if (w_accept && w_mem_rd) begin
            r_mem_q <= r_chroma_line[w_addr];
        end
    end

    // Stage one registers
    logic [PIX_W-1:0] r_s1_luma, r_s1_cb, r_s1_cr;
    logic [1:0]       r_s1_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_luma <= w_luma;
            r_s1_cb   <= w_cb;
            r_s1_cr   <= w_cr;
            r_s1_kind <= w_kind;
        end
    end

    // Averaging against the stored row, sum halved and truncated
    logic [PIX_W:0]   w_cb_avg, w_cr_avg;
    logic [PIX_W-1:0] n_out_cb, n_out_cr;
    logic             n_out_cv;

    assign w_cb_avg = {1'b0, r_mem_q[15:8]} + {1'b0, r_s1_cb};
    assign w_cr_avg = {1'b0, r_mem_q[7:0]} + {1'b0, r_s1_cr};

    always_comb begin
        case (r_s1_kind)
            CK_DIRECT: begin
                n_out_cv = 1'b1;
                n_out_cb = r_s1_cb;
                n_out_cr = r_s1_cr;
            end
            CK_AVG: begin
                n_out_cv = 1'b1;
                n_out_cb = w_cb_avg[PIX_W:1];
                n_out_cr = w_cr_avg[PIX_W:1];
            end
            default: begin
                n_out_cv = 1'b0;
                n_out_cb = '0;
                n_out_cr = '0;
            end
        endcase
    end

    // Output register
    logic [PIX_W-1:0] r_out_luma, r_out_cb, r_out_cr;
    logic             r_out_cv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_out_luma <= r_s1_luma;
            r_out_cv   <= n_out_cv;
            r_out_cb   <= n_out_cb;
            r_out_cr   <= n_out_cr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_cr, r_out_cb, r_out_luma};
    assign m_axis_tuser  = r_out_cv;

endmodule

// File: sv/rgb2yuv_checker.sv
// Port-level checker for the RGB to YCbCr converter, with its bind statement.
// Watches the output beat and the APB port over time.
// Depends on rgb2yuv_pkg and the top level rgb_to_yuv_chroma_subsampler.
module rgb2yuv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,  // luma[7:0], cb[15:8], cr[23:16]
    input logic        m_axis_tuser   // chroma_valid
);
    import rgb2yuv_pkg::*;

    // A stalled output beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // Without a chroma sample the chroma bytes read as zero.
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
        else $error("chroma bytes set without chroma_valid");

    // Luma stays inside the studio range.
    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] >= 8'(LUMA_MIN))
                       && (m_axis_tdata[7:0] <= 8'(LUMA_MAX)))
        else $error("luma out of range");

    // Direct and averaged chroma both stay inside the studio range.
    a_chroma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[15:8] >= 8'(CHROMA_MIN)) && (m_axis_tdata[15:8] <= 8'(CHROMA_MAX))
            && (m_axis_tdata[23:16] >= 8'(CHROMA_MIN))
            && (m_axis_tdata[23:16] <= 8'(CHROMA_MAX)))
        else $error("chroma out of range");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind rgb_to_yuv_chroma_subsampler rgb2yuv_checker u_rgb2yuv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/tb_rgb_to_yuv_chroma_subsampler.sv
// Self-checking bench for the RGB to YCbCr converter with chroma subsampling.
// It predicts every output beat and checks it against the converted stream.
// Depends on rgb2yuv_pkg and rgb_to_yuv_chroma_subsampler.
module tb_rgb_to_yuv_chroma_subsampler;
    timeunit 1ns;
    timeprecision 1ps;

    import rgb2yuv_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH_DEF / 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PIXELS = 1150;
    localparam logic [APB_AW-1:0] ADDR_MODE  = {REG_CHROMA_MODE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_WIDTH = {REG_LINE_WIDTH, 2'b00};

    typedef struct packed {
        logic       fs;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic [7:0] luma;
        logic       has_chroma;
        logic [7:0] cb;
        logic [7:0] cr;
    } t_yuv;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata = '0;  // red[7:0], green[15:8], blue[23:16]
    logic              s_axis_tuser = 1'b0;  // frame_start
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;  // luma[7:0], cb[15:8], cr[23:16]
    logic              m_axis_tuser;  // chroma_valid

    // Stimulus and expectation stores.
    t_pixel pixel_q[$];
    t_yuv   yuv_due[$];
    int     owed = 0;
    int     errors = 0;
    int     cycles = 0;
    int     src_gap = 0;
    int     sink_gap = 0;
    bit     calm = 1'b0;

    // Predictor state: a private copy of the registers and the line position.
    logic [MODE_W-1:0] cfg_mode = CHROMA_MODE_RST;
    int                cfg_width = int'(LINE_WIDTH_RST);
    int                px_col = 0;
    logic              px_odd = 1'b0;
    logic [15:0]       chroma_store [0:STORE_DEPTH-1];

    rgb_to_yuv_chroma_subsampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Effective line length: clamped to 2..MAX_WIDTH_DEF and forced even.
    function automatic int span_of(input int width);
        int w;
        w = width;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        return w & ~1;
    endfunction

    // Converts one pixel and advances the line position and the chroma store.
    function automatic t_yuv convert_pixel(input logic [7:0] red, green, blue,
                                           input logic fs);
        int r, g, b, cb, cr, addr;
        logic [15:0] held;
        t_yuv o;
        r = red;
        g = green;
        b = blue;
        o = '0;
        if (fs) begin
            px_col = 0;
            px_odd = 1'b0;
        end
        // Signed arithmetic shifts floor toward minus infinity.
        o.luma = 8'(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
        cb = ((112 * b - 38 * r - 74 * g + 128) >>> 8) + 128;
        cr = ((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128;
        case (cfg_mode)
            MODE_444: begin
                o.has_chroma = 1'b1;
                o.cb = 8'(cb);
                o.cr = 8'(cr);
            end
            MODE_422: begin
                if (px_col % 2 == 0) begin
                    o.has_chroma = 1'b1;
                    o.cb = 8'(cb);
                    o.cr = 8'(cr);
                end
            end
            default: begin
                // 4:2:0, and the unused code behaves the same way.
                if (px_col % 2 == 0) begin
                    addr = px_col / 2;
                    if (!px_odd) begin
                        chroma_store[addr] = {8'(cb), 8'(cr)};
                    end else begin
                        held = chroma_store[addr];
                        o.has_chroma = 1'b1;
                        o.cb = 8'((int'(held[15:8]) + cb) / 2);
                        o.cr = 8'((int'(held[7:0]) + cr) / 2);
                    end
                end
            end
        endcase
        if (px_col + 1 >= span_of(cfg_width)) begin
            px_col = 0;
            px_odd = ~px_odd;
        end else begin
            px_col++;
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 40) begin
            $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        errors++;
    endtask

    task automatic push_pixel(input logic [7:0] red, green, blue, input logic fs);
        t_pixel p;
        p.fs = fs;
        p.red = red;
        p.green = green;
        p.blue = blue;
        pixel_q.push_back(p);
        owed++;
    endtask

    // Mostly random levels, with the black and full-scale ends now and then.
    function automatic logic [7:0] rand_level();
        if ($urandom_range(0, 7) == 0) begin
            return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_reg(input logic [APB_AW-1:0] addr, input int want);
        logic [APB_DW-1:0] rdata;
        apb_access(1'b0, addr, '0, rdata);
        if (rdata != APB_DW'(want)) begin
            report_mismatch($sformatf("register at 0x%0h", addr), rdata, want);
        end
    endtask

    // Writes a register, mirrors it into the predictor and reads it back.
    task automatic write_reg(input logic [APB_AW-1:0] addr, input int value);
        logic [APB_DW-1:0] rdata;
        apb_access(1'b1, addr, APB_DW'(value), rdata);
        if (addr == ADDR_MODE) begin
            cfg_mode = MODE_W'(value);
            check_reg(addr, value & 3);
        end else begin
            cfg_width = value & 11'h7FF;
            check_reg(addr, cfg_width);
        end
    endtask

    // Holds the sender until every pixel is accepted and every beat has come.
    task automatic settle();
        do @(posedge i_clk); while (owed != 0 || yuv_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Pixel driver: predicts each accepted beat and loads the next one.
    always @(posedge i_clk) begin
        t_pixel nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                yuv_due.push_back(convert_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                                s_axis_tdata[23:16], s_axis_tuser));
                owed--;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (!calm && pixel_q.size() != 0 && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 6);
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    nxt = pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {nxt.blue, nxt.green, nxt.red};
                    s_axis_tuser <= nxt.fs;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output stall generator.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            sink_gap = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Output monitor: each beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_yuv want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (yuv_due.size() == 0) begin
                report_mismatch("beat with nothing pending", m_axis_tdata, 0);
            end else begin
                want = yuv_due.pop_front();
                if (m_axis_tdata[7:0] != want.luma)
                    report_mismatch("luma", m_axis_tdata[7:0], want.luma);
                if (m_axis_tuser != want.has_chroma)
                    report_mismatch("chroma_valid", m_axis_tuser, want.has_chroma);
                if (m_axis_tdata[15:8] != want.cb)
                    report_mismatch("cb", m_axis_tdata[15:8], want.cb);
                if (m_axis_tdata[23:16] != want.cr)
                    report_mismatch("cr", m_axis_tdata[23:16], want.cr);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL rgb_to_yuv_chroma_subsampler");
            $finish;
        end
    end

    // Test sequence: directed corners first, then random frames.
    initial begin
        int mode, width, span, count, sent, pick;
        sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reg(ADDR_MODE, int'(CHROMA_MODE_RST));
        check_reg(ADDR_WIDTH, int'(LINE_WIDTH_RST));

        // Reset setting: the first row of a 4:2:0 frame carries no chroma.
        push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        settle();

        // 4:4:4 with an oversized width; blue, yellow and cyan reach chroma extremes.
        write_reg(ADDR_MODE, int'(MODE_444));
        write_reg(ADDR_WIDTH, 2047);
        push_pixel(8'd0, 8'd0, 8'd255, 1'b1);
        push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd255, 1'b0);
        settle();

        // Unused mode code at the narrowest line: rows of two pixels.
        write_reg(ADDR_MODE, 3);
        write_reg(ADDR_WIDTH, 0);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        push_pixel(8'd128, 8'd64, 8'd32, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd1, 8'd2, 8'd3, 1'b0);
        settle();

        // 4:2:2, stop in the middle of a line, then shrink the line under it.
        write_reg(ADDR_MODE, int'(MODE_422));
        write_reg(ADDR_WIDTH, 16);
        push_pixel(8'd10, 8'd200, 8'd30, 1'b1);
        for (int k = 1; k < 7; k++) push_pixel(8'(k * 37), 8'(255 - k * 20), 8'(k * 11), 1'b0);
        settle();
        write_reg(ADDR_WIDTH, 5);
        push_pixel(8'd90, 8'd90, 8'd90, 1'b0);
        push_pixel(8'd250, 8'd5, 8'd128, 1'b0);
        push_pixel(8'd7, 8'd77, 8'd177, 1'b0);
        settle();

        // Random frames, each starting on a frame boundary with its own setting.
        while (sent < RANDOM_PIXELS) begin
            if (sent > RANDOM_PIXELS * 5 / 6) calm = 1'b1;
            mode = ($urandom_range(0, 2) == 0) ? int'(MODE_420) : $urandom_range(0, 3);
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                case ($urandom_range(0, 4))
                    0: width = 0;
                    1: width = 1;
                    2: width = 1024;
                    3: width = 1025;
                    default: width = 2047;
                endcase
            end else if (pick < 4) begin
                width = $urandom_range(1, 16) * 2 + 1;
            end else begin
                width = $urandom_range(1, 16) * 2;
            end
            span = span_of(width);
            if (span > 64) begin
                count = $urandom_range(20, 60);
            end else begin
                count = span * $urandom_range(2, 8);
                if ($urandom_range(0, 3) == 0) count += $urandom_range(0, span - 1);
            end
            write_reg(ADDR_MODE, mode);
            write_reg(ADDR_WIDTH, width);
            for (int k = 0; k < count; k++) begin
                push_pixel(rand_level(), rand_level(), rand_level(),
                           k == 0 || $urandom_range(0, 99) == 0);
            end
            sent += count;
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0 && yuv_due.size() == 0) begin
            $display("PASS rgb_to_yuv_chroma_subsampler");
        end else begin
            $display("FAIL rgb_to_yuv_chroma_subsampler");
        end
        $finish;
    end

endmodule
